/* design/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the frame replacement table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/lfrt_pkg.sv */
// Shared types, field widths and codes of the frame replacement table.
package lfrt_pkg;

  // Field widths of the channels and registers
  localparam int CMD_W    = 2;
  localparam int PID_W    = 4;
  localparam int FIDX_W   = 6;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 7;
  localparam int LIMIT_W  = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Default table size
  localparam int DEF_NUM_FRAMES    = 64;
  localparam int DEF_NUM_PROCESSES = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVICT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  // Result status
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOEVICT = 2'd2;

  // Register indexes (paddr bit 2)
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  // Replacement policy
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd8;

  typedef struct packed {
    logic               policy;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } ctrl_sts_t;

endpackage

/* design/lfrt_if.sv */
// Valid/ready channel interfaces for requests and results.
interface lfrt_in_if import lfrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [PID_W-1:0]  proc_id;
  logic [FIDX_W-1:0] frame_sel;

  modport source (output valid, cmd, proc_id, frame_sel, input ready);
  modport sink (input valid, cmd, proc_id, frame_sel, output ready);
endinterface

interface lfrt_out_if import lfrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FIDX_W-1:0]   frame_out;
  logic [PID_W-1:0]    evicted_owner;
  logic [STATUS_W-1:0] status;
  logic                can_allocate;
  logic [HELD_W-1:0]   held_frames;

  modport source (output valid, frame_out, evicted_owner, status, can_allocate,
                  held_frames, input ready);
  modport sink (input valid, frame_out, evicted_owner, status, can_allocate,
                held_frames, output ready);
endinterface

/* design/lfrt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module lfrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/lfrt_cfg.sv */
// APB-style configuration registers: policy mode and per-process limit.
module lfrt_cfg import lfrt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic               policy_r, policy_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic               wr_en;
  logic               reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[PADDR_W-1];
  assign pready  = 1'b1;

  // Decode writes
  always_comb begin
    policy_nxt = policy_r;
    limit_nxt  = limit_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_POLICY: policy_nxt = pwdata[0];
        REG_LIMIT:  limit_nxt  = pwdata[LIMIT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_FIFO;
      limit_r  <= LIMIT_RESET;
    end else begin
      policy_r <= policy_nxt;
      limit_r  <= limit_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      REG_POLICY: prdata = PDATA_W'(policy_r);
      REG_LIMIT:  prdata = PDATA_W'(limit_r);
    endcase
  end

  assign cfg.policy = policy_r;
  assign cfg.limit  = limit_r;

endmodule

/* design/lfrt_ctrl.sv */
// Command sequencer: frame and count memories, sweeps and result register.
module lfrt_ctrl import lfrt_pkg::*; #(
  parameter int NUM_FRAMES    = DEF_NUM_FRAMES,
  parameter int NUM_PROCESSES = DEF_NUM_PROCESSES
) (
  input  logic       clk,
  input  logic       rst_n,
  lfrt_in_if.sink    in_ch,
  lfrt_out_if.source out_ch,
  input  cfg_t       cfg,
  output ctrl_sts_t  sts
);

  localparam int FW    = $clog2(NUM_FRAMES);
  localparam int PW    = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int CW    = $clog2(NUM_FRAMES + 1);
  localparam int LW    = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int EW    = 1 + PW + FW;
  localparam int CLR_N = (NUM_FRAMES > NUM_PROCESSES) ? NUM_FRAMES : NUM_PROCESSES;
  localparam int CLRW  = $clog2(CLR_N);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  typedef struct packed {
    logic          used;
    logic [PW-1:0] owner;
    logic [FW-1:0] rank;
  } entry_t;

  // Frame memory and count memory ports
  logic          fm_we;
  logic [FW-1:0] fm_waddr, fm_raddr;
  entry_t        fm_wdata, fm_rdata;
  logic          cm_we;
  logic [PW-1:0] cm_waddr, cm_raddr;
  logic [CW-1:0] cm_wdata, cm_rdata;

  // Sequencer state
  logic [2:0]          state_r, state_nxt;
  logic [CLRW-1:0]     clr_r, clr_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [PID_W-1:0]    pid_r, pid_nxt;
  logic [FIDX_W-1:0]   fi_r, fi_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [FW-1:0]       rank_r, rank_nxt;
  logic [FW-1:0]       sa_r, sa_nxt;
  logic                iss_r, iss_nxt;
  logic                pv_r, pv_nxt;
  logic [FW-1:0]       pa_r, pa_nxt;
  logic [FW-1:0]       res_frame_r, res_frame_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic [FIDX_W-1:0]   out_frame_r, out_frame_nxt;
  logic [PID_W-1:0]    out_owner_r, out_owner_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_can_r, out_can_nxt;
  logic [HELD_W-1:0]   out_held_r, out_held_nxt;

  logic          pid_ok;
  logic          fi_ok;
  logic [PW-1:0] pid_idx;
  logic          own_hit;
  logic          last_beat;

  lfrt_ram #(.WIDTH(EW), .DEPTH(NUM_FRAMES)) u_frame_mem (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  lfrt_ram #(.WIDTH(CW), .DEPTH(NUM_PROCESSES)) u_count_mem (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (cm_wdata),
    .raddr (cm_raddr),
    .rdata (cm_rdata)
  );

  assign pid_ok    = 32'(pid_r) < 32'(NUM_PROCESSES);
  assign fi_ok     = 32'(fi_r) < 32'(NUM_FRAMES);
  assign pid_idx   = PW'(pid_r);
  assign own_hit   = fm_rdata.used && (fm_rdata.owner == pid_idx);
  assign last_beat = pv_r && (pa_r == FW'(NUM_FRAMES - 1));

  // Read addresses: request frame on accept, sweep pointer otherwise; count memory reads the request process
  assign fm_raddr = (state_r == S_IDLE) ? FW'(in_ch.frame_sel) : sa_r;
  assign cm_raddr = PW'(in_ch.proc_id);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cmd_nxt        = cmd_r;
    pid_nxt        = pid_r;
    fi_nxt         = fi_r;
    cnt_nxt        = cnt_r;
    rank_nxt       = rank_r;
    sa_nxt         = sa_r;
    iss_nxt        = iss_r;
    pv_nxt         = pv_r;
    pa_nxt         = pa_r;
    res_frame_nxt  = res_frame_r;
    res_status_nxt = res_status_r;
    out_frame_nxt  = out_frame_r;
    out_owner_nxt  = out_owner_r;
    out_status_nxt = out_status_r;
    out_can_nxt    = out_can_r;
    out_held_nxt   = out_held_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    fm_we          = 1'b0;
    fm_waddr       = pa_r;
    fm_wdata       = fm_rdata;
    cm_we          = 1'b0;
    cm_waddr       = pid_idx;
    cm_wdata       = cnt_r;

    unique case (state_r)
      // Clear both memories, one entry per cycle
      S_CLEAR: begin
        fm_we    = 32'(clr_r) < 32'(NUM_FRAMES);
        fm_waddr = FW'(clr_r);
        fm_wdata = '0;
        cm_we    = 32'(clr_r) < 32'(NUM_PROCESSES);
        cm_waddr = PW'(clr_r);
        cm_wdata = '0;
        if (clr_r == CLRW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      // Take a request beat; memories read the frame and the count
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          pid_nxt   = in_ch.proc_id;
          fi_nxt    = in_ch.frame_sel;
          state_nxt = S_LOOK;
        end
      end

      // Decide whether a sweep is needed
      S_LOOK: begin
        cnt_nxt        = cm_rdata;
        rank_nxt       = fm_rdata.rank;
        sa_nxt         = '0;
        iss_nxt        = 1'b1;
        pv_nxt         = 1'b0;
        res_frame_nxt  = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_OUT;
        case (cmd_r)
          CMD_ALLOC: begin
            if (pid_ok && (LW'(cm_rdata) < LW'(cfg.limit))) begin
              state_nxt = S_SWEEP;
            end else begin
              res_status_nxt = ST_FULL;
            end
          end
          CMD_TOUCH: begin
            if (pid_ok && (cfg.policy == POLICY_LRU) && fi_ok && own_hit) begin
              state_nxt = S_SWEEP;
            end
          end
          CMD_EVICT: begin
            if (pid_ok && (cm_rdata != '0)) begin
              state_nxt = S_SWEEP;
            end else begin
              res_status_nxt = ST_NOEVICT;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end

      // Walk the frames (allocate stops at the first free one): read one, update the one read in the previous cycle
      S_SWEEP: begin
        pv_nxt = iss_r;
        if (iss_r) begin
          pa_nxt = sa_r;
          if (sa_r == FW'(NUM_FRAMES - 1)) begin
            iss_nxt = 1'b0;
          end else begin
            sa_nxt = sa_r + 1'b1;
          end
        end
        if (pv_r) begin
          case (cmd_r)
            CMD_ALLOC: begin
              if (!fm_rdata.used) begin
                fm_we          = 1'b1;
                fm_wdata.used  = 1'b1;
                fm_wdata.owner = pid_idx;
                fm_wdata.rank  = FW'(cnt_r);
                res_frame_nxt  = pa_r;
                cnt_nxt        = cnt_r + 1'b1;
                cm_we          = 1'b1;
                cm_wdata       = cnt_r + 1'b1;
                state_nxt      = S_OUT;
              end else if (last_beat) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_OUT;
              end
            end
            CMD_TOUCH: begin
              if (own_hit) begin
                if (pa_r == FW'(fi_r)) begin
                  fm_we         = 1'b1;
                  fm_wdata.rank = FW'(cnt_r - 1'b1);
                end else if (fm_rdata.rank > rank_r) begin
                  fm_we         = 1'b1;
                  fm_wdata.rank = fm_rdata.rank - 1'b1;
                end
              end
              if (last_beat) begin
                state_nxt = S_OUT;
              end
            end
            CMD_EVICT: begin
              if (own_hit) begin
                fm_we = 1'b1;
                if (fm_rdata.rank == '0) begin
                  fm_wdata.used = 1'b0;
                  res_frame_nxt = pa_r;
                end else begin
                  fm_wdata.rank = fm_rdata.rank - 1'b1;
                end
              end
              if (last_beat) begin
                cnt_nxt   = cnt_r - 1'b1;
                cm_we     = 1'b1;
                cm_wdata  = cnt_r - 1'b1;
                state_nxt = S_OUT;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end

      // Load the result register once it is free
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_frame_nxt  = FIDX_W'(res_frame_r);
          out_status_nxt = res_status_r;
          out_owner_nxt  = ((cmd_r == CMD_EVICT) && (res_status_r == ST_OK)) ?
                           pid_r : '0;
          out_held_nxt   = pid_ok ? HELD_W'(cnt_r) : '0;
          out_can_nxt    = pid_ok && (LW'(cnt_r) < LW'(cfg.limit));
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      iss_r       <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_r       <= iss_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pid_r        <= pid_nxt;
    fi_r         <= fi_nxt;
    cnt_r        <= cnt_nxt;
    rank_r       <= rank_nxt;
    sa_r         <= sa_nxt;
    pa_r         <= pa_nxt;
    res_frame_r  <= res_frame_nxt;
    res_status_r <= res_status_nxt;
    out_frame_r  <= out_frame_nxt;
    out_owner_r  <= out_owner_nxt;
    out_status_r <= out_status_nxt;
    out_can_r    <= out_can_nxt;
    out_held_r   <= out_held_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_out     = out_frame_r;
  assign out_ch.evicted_owner = out_owner_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.can_allocate  = out_can_r;
  assign out_ch.held_frames   = out_held_r;

  assign sts.clearing = (state_r == S_CLEAR);
  assign sts.busy     = (state_r != S_IDLE);

endmodule

/* design/local_frame_replacement_table.sv */
// Query requests and requests refused in the look state go straight to the result register;
// allocate, touch and evict first sweep the frame memory (allocate stops at a free frame).
// One request at a time: the next is taken once the last has reached the result register.
// The result register lets the next request in while a result beat waits.
// Reset (synchronous, rst_n low) starts a clearing pass over both memories; requests wait
// until it ends, configuration writes do not.
`include "assert_macros.svh"
module local_frame_replacement_table import lfrt_pkg::*; #(
  parameter int NUM_FRAMES    = DEF_NUM_FRAMES,
  parameter int NUM_PROCESSES = DEF_NUM_PROCESSES
) (
  input  logic               clk,
  input  logic               rst_n,
  lfrt_in_if.sink            in_ch,
  lfrt_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t      cfg;
  ctrl_sts_t sts;

  lfrt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfrt_ctrl #(
    .NUM_FRAMES    (NUM_FRAMES),
    .NUM_PROCESSES (NUM_PROCESSES)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg),
    .sts    (sts)
  );

  // Checks on the sequencer
  `ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_ch.valid && in_ch.ready, sts.busy,
              "request beat did not start work")
  `ASSERT_IMP(a_no_beat_clearing, clk, rst_n, sts.clearing, !in_ch.ready,
              "request taken during clearing pass")
  `ASSERT_IMP(a_fail_zero_frame, clk, rst_n, out_ch.valid && (out_ch.status != ST_OK),
              (out_ch.frame_out == '0) && (out_ch.evicted_owner == '0),
              "failed result carries a frame")
  `ASSERT_IMP(a_noevict_empty, clk, rst_n, out_ch.valid && (out_ch.status == ST_NOEVICT),
              out_ch.held_frames == '0, "nothing to evict but frames held")

endmodule
